### rtl/core/jses_pkg.sv
// shared types and constants for the json string escaper
// job descriptor passed from the front end to the back end through the queue
// no dependencies
package jses_pkg;

   // action codes of an input word
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_DATA  = 2'd1;
   localparam logic [1:0] ACT_END   = 2'd2;

   // character constants
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;

   // u+fffd in utf-8
   localparam logic [7:0] REPL_B0 = 8'hEF;
   localparam logic [7:0] REPL_B1 = 8'hBF;
   localparam logic [7:0] REPL_B2 = 8'hBD;

   // job queue geometry
   localparam int FifoDepth    = 2;
   localparam int FifoPtrWidth = $clog2(FifoDepth);

   // what follows the replacement and pass-through parts of a job
   typedef enum logic [2:0] {
      TAIL_NONE = 3'd0,   // nothing
      TAIL_BYTE = 3'd1,   // one literal byte
      TAIL_ESC  = 3'd2,   // backslash then tail_byte
      TAIL_UNI  = 3'd3,   // \u00 then two hex digits of tail_byte
      TAIL_REPL = 3'd4    // one replacement character
   } tail_kind_type;

   // one input word's worth of output: replacements, pass bytes, tail
   typedef struct packed {
      logic [3:0]      repl_len;    // bytes of leading replacements
      logic [3:0]      pass_end;    // end index of the pass-through bytes
      logic [3:0]      total_len;   // total output bytes, never zero
      logic [3:0][7:0] pass_bytes;
      tail_kind_type   tail_kind;
      logic [7:0]      tail_byte;
   } job_type;

endpackage

### rtl/core/jses_if.sv
// valid/ready channel interfaces for the request and response sides
// no dependencies
interface jses_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface jses_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

### rtl/core/json_string_escaper_utf8_sanitizer.sv
// json string escaper with strict utf-8 sanitizing, top level
// path: with the queue empty the first word of an item is registered in the job queue, then in the output register
// throughput: one output word per cycle while rsp is ready; one item per cycle while items give one word
// items that expand (escapes, replacements, flushed runs) hold req once the
// two-entry job queue is full; the back end's byte counter sets the pace
// reset: synchronous active high; clears the run tracking, queue and output valid
module json_string_escaper_utf8_sanitizer import jses_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   jses_req_if.sink   req_chan,
   jses_rsp_if.source rsp_chan
);

   // front to queue
   job_type front_job;
   logic    front_valid;
   logic    front_ready;

   // queue to back
   job_type head_job;
   logic    head_valid;
   logic    head_pop;

   // front end: classifies each word and keeps the pending utf-8 run;
   // words that only extend a run make no job and cost no output cycle
   jses_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .job       (front_job),
      .job_valid (front_valid),
      .job_ready (front_ready)
   );

   // job queue lets the front keep taking words while the back drains
   jses_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_job   (front_job),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .head_job   (head_job),
      .head_valid (head_valid),
      .pop        (head_pop)
   );

   // back end: walks the head job one output byte per cycle, while the output is free, into the
   // output register, popping it on its last byte
   jses_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .head_valid (head_valid),
      .pop        (head_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

### rtl/core/jses_front.sv
// front end: accepts request words, tracks the utf-8 run, builds jobs
// depends on jses_pkg and jses_req_if
module jses_front import jses_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   jses_req_if.sink req_chan,
   output job_type  job,
   output logic     job_valid,
   input  logic     job_ready
);

   logic [2:0][7:0] held_ff, held_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic [1:0]      exp_ff, exp_in;

   logic            accept;
   logic [7:0]      b;

   // fresh classification of the incoming byte
   tail_kind_type   fr_kind;
   logic [7:0]      fr_byte;
   logic [1:0]      fr_need;

   logic [7:0]      lo, hi;
   logic [1:0]      n_repl;
   logic [2:0]      n_pass;
   logic [3:0]      repl_len, pass_end, tail_len, total_len;
   tail_kind_type   kind;
   logic [7:0]      tbyte;
   logic [3:0][7:0] pass;

   assign b        = req_chan.data_byte;
   assign req_chan.ready = job_ready;
   assign accept   = req_chan.valid && job_ready;

   always_comb begin
      fr_kind = TAIL_BYTE;
      fr_byte = b;
      fr_need = 2'd0;
      if (b >= 8'h80) begin
         if (b >= 8'hC2 && b <= 8'hDF) begin
            fr_need = 2'd1;
         end else if (b >= 8'hE0 && b <= 8'hEF) begin
            fr_need = 2'd2;
         end else if (b >= 8'hF0 && b <= 8'hF4) begin
            fr_need = 2'd3;
         end
         fr_kind = (fr_need == 2'd0) ? TAIL_REPL : TAIL_NONE;
      end else begin
         unique case (b)
            8'h22: begin fr_kind = TAIL_ESC; fr_byte = CHAR_QUOTE;  end
            8'h5C: begin fr_kind = TAIL_ESC; fr_byte = CHAR_BSLASH; end
            8'h08: begin fr_kind = TAIL_ESC; fr_byte = 8'h62;       end
            8'h0C: begin fr_kind = TAIL_ESC; fr_byte = 8'h66;       end
            8'h0A: begin fr_kind = TAIL_ESC; fr_byte = 8'h6E;       end
            8'h0D: begin fr_kind = TAIL_ESC; fr_byte = 8'h72;       end
            8'h09: begin fr_kind = TAIL_ESC; fr_byte = 8'h74;       end
            default: begin
               if (b < 8'h20) begin
                  fr_kind = TAIL_UNI;
               end
            end
         endcase
      end
   end

   // strict limits on the first continuation byte
   always_comb begin
      lo = 8'h80;
      hi = 8'hBF;
      if (cnt_ff == 2'd1) begin
         unique case (held_ff[0])
            8'hE0:   lo = 8'hA0;
            8'hED:   hi = 8'h9F;
            8'hF0:   lo = 8'h90;
            8'hF4:   hi = 8'h8F;
            default: ;
         endcase
      end
   end

   always_comb begin
      held_in = held_ff;
      cnt_in  = cnt_ff;
      exp_in  = exp_ff;
      n_repl  = 2'd0;
      n_pass  = 3'd0;
      kind    = TAIL_NONE;
      tbyte   = b;
      pass    = {b, held_ff[2], held_ff[1], held_ff[0]};

      unique case (req_chan.action)
         ACT_START: begin
            cnt_in = 2'd0;
            exp_in = 2'd0;
            kind   = TAIL_BYTE;
            tbyte  = CHAR_QUOTE;
         end
         ACT_END: begin
            n_repl = cnt_ff;
            cnt_in = 2'd0;
            exp_in = 2'd0;
            kind   = TAIL_BYTE;
            tbyte  = CHAR_QUOTE;
         end
         ACT_DATA: begin
            if (cnt_ff == 2'd0 || exp_ff == 2'd0 || b < lo || b > hi) begin
               // broken run flushes first, then the byte is taken afresh
               if (cnt_ff != 2'd0 && exp_ff != 2'd0) begin
                  n_repl = cnt_ff;
               end
               kind  = fr_kind;
               tbyte = fr_byte;
               if (fr_need != 2'd0) begin
                  held_in[0] = b;
                  cnt_in     = 2'd1;
                  exp_in     = fr_need;
               end else begin
                  cnt_in = 2'd0;
                  exp_in = 2'd0;
               end
            end else if (cnt_ff >= exp_ff) begin
               // run complete and valid
               pass[cnt_ff] = b;
               n_pass       = {1'b0, cnt_ff} + 3'd1;
               cnt_in       = 2'd0;
               exp_in       = 2'd0;
            end else begin
               held_in[cnt_ff] = b;
               cnt_in          = cnt_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      unique case (kind)
         TAIL_NONE: tail_len = 4'd0;
         TAIL_BYTE: tail_len = 4'd1;
         TAIL_ESC:  tail_len = 4'd2;
         TAIL_UNI:  tail_len = 4'd6;
         TAIL_REPL: tail_len = 4'd3;
         default:   tail_len = 4'd0;
      endcase
   end

   assign repl_len  = {1'b0, n_repl, 1'b0} + {2'b00, n_repl};
   assign pass_end  = repl_len + {1'b0, n_pass};
   assign total_len = pass_end + tail_len;

   assign job.repl_len   = repl_len;
   assign job.pass_end   = pass_end;
   assign job.total_len  = total_len;
   assign job.pass_bytes = pass;
   assign job.tail_kind  = kind;
   assign job.tail_byte  = tbyte;
   assign job_valid      = accept && (total_len != 4'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         exp_ff <= 2'd0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
         exp_ff <= exp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

### rtl/core/jses_fifo.sv
// short job queue between the front end and the back end
// depends on jses_pkg
module jses_fifo import jses_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  job_type push_job,
   input  logic    push_valid,
   output logic    push_ready,
   output job_type head_job,
   output logic    head_valid,
   input  logic    pop
);

   job_type                 slot_ff [FifoDepth];
   logic [FifoPtrWidth-1:0] wr_ff, rd_ff;
   logic [FifoPtrWidth:0]   count_ff;
   logic                    do_push, do_pop;

   assign push_ready = (count_ff != (FifoPtrWidth + 1)'(FifoDepth));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

### rtl/core/jses_back.sv
// back end: expands the head job into output words, one per cycle while the output register is free
// depends on jses_pkg and jses_rsp_if
module jses_back import jses_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  job_type    head_job,
   input  logic       head_valid,
   output logic       pop,
   jses_rsp_if.source rsp_chan
);

   logic [3:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;

   logic       fire, last;
   logic [3:0] pass_idx, tail_idx;
   logic [7:0] cur_byte, hex_hi, hex_lo;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] res;
      if (nib < 4'd10) begin
         res = 8'h30 + {4'h0, nib};
      end else begin
         res = 8'h57 + {4'h0, nib};
      end
      return res;
   endfunction

   assign fire     = head_valid && (!out_valid_ff || rsp_chan.ready);
   assign last     = (idx_ff == head_job.total_len - 4'd1);
   assign pop      = fire && last;
   assign pass_idx = idx_ff - head_job.repl_len;
   assign tail_idx = idx_ff - head_job.pass_end;
   assign hex_hi   = hex_char(head_job.tail_byte[7:4]);
   assign hex_lo   = hex_char(head_job.tail_byte[3:0]);

   always_comb begin
      cur_byte = 8'h00;
      if (idx_ff < head_job.repl_len) begin
         // position within a replacement triple
         unique case (idx_ff)
            4'd0, 4'd3, 4'd6: cur_byte = REPL_B0;
            4'd1, 4'd4, 4'd7: cur_byte = REPL_B1;
            default:          cur_byte = REPL_B2;
         endcase
      end else if (idx_ff < head_job.pass_end) begin
         cur_byte = head_job.pass_bytes[pass_idx[1:0]];
      end else begin
         unique case (head_job.tail_kind)
            TAIL_BYTE: cur_byte = head_job.tail_byte;
            TAIL_ESC:  cur_byte = (tail_idx == 4'd0) ? CHAR_BSLASH : head_job.tail_byte;
            TAIL_UNI: begin
               unique case (tail_idx)
                  4'd0:       cur_byte = CHAR_BSLASH;
                  4'd1:       cur_byte = CHAR_U;
                  4'd2, 4'd3: cur_byte = CHAR_ZERO;
                  4'd4:       cur_byte = hex_hi;
                  default:    cur_byte = hex_lo;
               endcase
            end
            TAIL_REPL: begin
               unique case (tail_idx)
                  4'd0:    cur_byte = REPL_B0;
                  4'd1:    cur_byte = REPL_B1;
                  default: cur_byte = REPL_B2;
               endcase
            end
            default:   cur_byte = 8'h00;
         endcase
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (fire) begin
         idx_in       = last ? 4'd0 : idx_ff + 4'd1;
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_byte_ff <= cur_byte;
         out_last_ff <= last;
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.out_byte = out_byte_ff;
   assign rsp_chan.out_last = out_last_ff;

endmodule
